### sv/fcmb_pkg.sv
package fcmb_pkg;

  localparam int FRAME_BYTES  = 14;
  localparam int MOTOR_COUNT  = 3;
  localparam int PACKET_BYTES = 6;
  localparam int QDEPTH       = 2;

  // configuration register indexes
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;

  // frame types
  localparam logic [7:0] TYPE_ANGLE = 8'd1;
  localparam logic [7:0] TYPE_CMD4  = 8'd4;
  localparam logic [7:0] TYPE_CMD5  = 8'd5;
  localparam logic [7:0] TYPE_CMD6  = 8'd6;

  // work handed from the front end to the packet engine
  typedef struct packed {
    logic        is_frame;  // a frame is complete and must be decoded
    logic [7:0]  kind;
    logic [95:0] payload;   // frame bytes 2..13, byte 2 in bits 7:0
    logic        ok_led;
    logic        discard_led;
  } fcmb_job_t;

endpackage

### sv/framed_command_to_motor_packet_bridge_unit.sv
// Bridge from framed command bytes to 6-byte motor packets. Each input beat
// (a received byte or a millisecond tick) gives one or more output beats; the
// last carries out_tx_last. A beat that causes no packet passes through the
// queue and then the output register, and such beats flow one per cycle
// while neither the queue nor the output stalls. A frame that sends packets
// holds the packet engine: a start in the idle state, then for each angle
// packet float scaling (two multiply stages and a rounding register) and six
// byte beats, for each command packet the calc state and six byte beats;
// leading zero-flag motors are stepped over in the calc state. Output stalls
// hold it longer. The front end keeps accepting beats into a two-entry queue.
module framed_command_to_motor_packet_bridge_unit
  import fcmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_ok_led,
  output logic        out_discard_led,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  fcmb_job_t fq_job, qb_job;

  fcmb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_rx_byte(in_rx_byte), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  fcmb_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_job(fq_job), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  fcmb_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(qb_valid), .job_ready(qb_ready),
    .job(qb_job), .out_valid(out_valid), .out_stall(out_stall),
    .out_tx_valid(out_tx_valid), .out_tx_byte(out_tx_byte),
    .out_tx_last(out_tx_last), .out_ok_led(out_ok_led),
    .out_discard_led(out_discard_led)
  );

`ifndef SYNTH
  a_noinvalid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'd0 && out_tx_last)
    else $error("idle beat carries data");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte))
    else $error("stalled beat changed");
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("config port not ready");
`endif

endmodule

### sv/fcmb_front.sv
module fcmb_front
  import fcmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        job_valid,
  input  logic        job_ready,
  output fcmb_job_t   job
);

  logic [7:0]  header_r, timeout_r;
  logic [15:0] hold_r;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  idle_r, idle_nxt, idle_inc;
  logic [15:0] okh_r, okh_nxt, dsh_r, dsh_nxt;
  logic [7:0]  store_r [FRAME_BYTES-1];
  logic        acc;
  logic        done;
  fcmb_job_t   job_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = !job_ready;
  assign acc       = in_valid && job_ready;
  assign job_valid = acc;
  assign idle_inc  = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= 8'hAA;
      timeout_r <= 8'd10;
      hold_r    <= 16'd500;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HEADER)  header_r  <= cfg_data[7:0];
      if (cfg_index == REG_TIMEOUT) timeout_r <= cfg_data[7:0];
      if (cfg_index == REG_HOLD)    hold_r    <= cfg_data;
    end
  end

  // framing state update
  always_comb begin
    pos_nxt  = pos_r;
    idle_nxt = idle_r;
    okh_nxt  = okh_r;
    dsh_nxt  = dsh_r;
    done     = 1'b0;
    if (!in_command) begin
      if (pos_r == 4'd0) begin
        if (in_rx_byte == header_r) begin
          pos_nxt  = 4'd1;
          idle_nxt = 8'd0;
        end else begin
          dsh_nxt = hold_r;
        end
      end else begin
        idle_nxt = 8'd0;
        if (pos_r == 4'(FRAME_BYTES - 1)) begin
          pos_nxt = 4'd0;
          okh_nxt = hold_r;
          done    = 1'b1;
        end else begin
          pos_nxt = pos_r + 4'd1;
        end
      end
    end else begin
      if (okh_r != 16'd0) okh_nxt = okh_r - 16'd1;
      if (dsh_r != 16'd0) dsh_nxt = dsh_r - 16'd1;
      idle_nxt = idle_inc;
      if (pos_r != 4'd0 && idle_inc > timeout_r) begin
        pos_nxt = 4'd0;
        dsh_nxt = hold_r;
      end
    end
  end

  always_comb begin
    job_nxt.is_frame    = done;
    job_nxt.kind        = store_r[0];
    for (int i = 0; i < 11; i++) job_nxt.payload[i*8 +: 8] = store_r[i+1];
    job_nxt.payload[95:88] = in_rx_byte;
    job_nxt.ok_led      = okh_nxt != 16'd0;
    job_nxt.discard_led = dsh_nxt != 16'd0;
  end
  assign job = job_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 4'd0;
      idle_r <= 8'd0;
      okh_r  <= 16'd0;
      dsh_r  <= 16'd0;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      idle_r <= idle_nxt;
      okh_r  <= okh_nxt;
      dsh_r  <= dsh_nxt;
    end
  end

  // frame byte store, bytes after the header
  always_ff @(posedge clk) begin
    if (acc && !in_command && pos_r != 4'd0)
      store_r[pos_r[3:0] - 4'd1] <= in_rx_byte;
  end

endmodule

### sv/fcmb_queue.sv
module fcmb_queue
  import fcmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  fcmb_job_t wr_job,
  output logic      rd_valid,
  input  logic      rd_ready,
  output fcmb_job_t rd_job
);

  fcmb_job_t  ent_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'(QDEPTH);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = ent_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) ent_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

endmodule

### sv/fcmb_scale.sv
module fcmb_scale
  import fcmb_pkg::*;
(
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] ang,
  output logic [31:0] res
);

  // Single float times 0.01745329 (rounded to double), result rounded to
  // double then to single. Stage 1 normalizes and forms the low partial
  // product, stage 2 adds the high partial product, then the rounded word
  // lands in res.
  // double 0.01745329 = 0x3F91DF467707C94D, mantissa with hidden bit
  localparam logic [52:0] KM = {1'b1, 52'h1DF467707C94D};
  localparam int          KEXP = -6;

  logic        s1_sign_r, s1_zero_r, s1_nan_r, s1_inf_r;
  logic [21:0] s1_nanf_r;
  logic signed [10:0] s1_exp_r;
  logic [23:0] s1_mn_r;
  logic [50:0] s1_lo_r;
  logic        s2_sign_r, s2_zero_r, s2_nan_r, s2_inf_r;
  logic [21:0] s2_nanf_r;
  logic signed [10:0] s2_exp_r;
  logic [76:0] s2_prod_r;
  logic [49:0] hi_pp;
  logic [23:0] m;
  logic [7:0]  e;
  logic        sub;
  logic [4:0]  lz;
  logic [23:0] mn;

  // normalize denormal inputs
  always_comb begin
    e   = ang[30:23];
    sub = e == 8'd0;
    m   = {!sub, ang[22:0]};
    lz  = 5'd0;
    for (int i = 0; i < 24; i++) if (m[i]) lz = 5'(23 - i);
    mn = m << lz;
  end

  // stage 1: classify, exponent, low partial product
  always_ff @(posedge clk) begin
    if (start) begin
      s1_sign_r <= ang[31];
      s1_zero_r <= m == 24'd0;
      s1_nan_r  <= e == 8'hFF && ang[22:0] != 23'd0;
      s1_inf_r  <= e == 8'hFF && ang[22:0] == 23'd0;
      s1_nanf_r <= ang[21:0];
      s1_exp_r  <= 11'(signed'({3'b0, e})) - 11'sd127 + 11'(sub) - 11'(lz) + 11'(KEXP);
      s1_mn_r   <= mn;
      s1_lo_r   <= mn * KM[26:0];
    end
  end

  // stage 2: high partial product and sum
  assign hi_pp = s1_mn_r * KM[52:27];

  always_ff @(posedge clk) begin
    s2_sign_r <= s1_sign_r;
    s2_zero_r <= s1_zero_r;
    s2_nan_r  <= s1_nan_r;
    s2_inf_r  <= s1_inf_r;
    s2_nanf_r <= s1_nanf_r;
    s2_exp_r  <= s1_exp_r;
    s2_prod_r <= 77'(s1_lo_r) + {hi_pp, 27'd0};
  end

  logic [76:0] p;
  logic signed [10:0] ex;
  logic [52:0] dm;
  logic        dr;
  logic [53:0] dmr;
  logic [24:0] fmr;
  logic signed [10:0] fe;
  logic [31:0] out_w;
  logic [5:0]  dsh;
  logic [77:0] sv;
  logic        st;

  always_comb begin
    p  = s2_prod_r;
    ex = s2_exp_r;
    if (p[76]) ex = ex + 11'sd1; else p = p << 1;
    // round to double: keep 53 bits
    dm  = p[76:24];
    dr  = p[23] && (p[22:0] != 23'd0 || p[24]);
    dmr = {1'b0, dm} + 54'(dr);
    if (dmr[53]) begin dmr = dmr >> 1; ex = ex + 11'sd1; end
    // round to single (with subnormal handling)
    out_w = 32'd0;
    fmr = 25'd0; fe = ex; dsh = 6'd0; sv = 78'd0; st = 1'b0;
    if (ex >= -11'sd126) begin
      fmr = {1'b0, dmr[52:29]} +
            25'(dmr[28] && (dmr[27:0] != 28'd0 || dmr[29]));
      if (fmr[24]) begin fmr = fmr >> 1; fe = fe + 11'sd1; end
      if (fe > 11'sd127) out_w = {s2_sign_r, 8'hFF, 23'd0};
      else out_w = {s2_sign_r, 8'(fe + 11'sd127), fmr[22:0]};
    end else begin
      dsh = (ex < -11'sd180) ? 6'd55 : 6'(-11'sd126 - ex);
      sv  = {dmr[52:0], 25'd0} >> dsh;
      st  = (dsh >= 6'd50) ? 1'b1 : 1'b0;
      fmr = {1'b0, sv[77:54]} + 25'(sv[53] && (sv[52:0] != 53'd0 || sv[54] ||
            (st && dmr[52:0] != 53'd0 && sv[53:0] == 54'd0)));
      if (fmr[23]) out_w = {s2_sign_r, 8'd1, fmr[22:0]};
      else out_w = {s2_sign_r, 8'd0, fmr[22:0]};
    end
    if (s2_zero_r) out_w = {s2_sign_r, 31'd0};
    if (s2_inf_r)  out_w = {s2_sign_r, 8'hFF, 23'd0};
    // NaN keeps sign and payload, quiet bit set
    if (s2_nan_r)  out_w = {s2_sign_r, 8'hFF, 1'b1, s2_nanf_r};
  end

  always_ff @(posedge clk) res <= out_w;

endmodule

### sv/fcmb_back.sv
module fcmb_back
  import fcmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  fcmb_job_t job,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic      out_tx_last,
  output logic      out_ok_led,
  output logic      out_discard_led
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_SEND = 3'd2;

  logic [2:0]  st_r;
  logic [1:0]  mot_r;
  logic [2:0]  byt_r;
  logic [1:0]  wait_r;
  logic [31:0] word_r;
  logic [31:0] sres;
  logic        sstart;
  logic [31:0] ang;
  logic        is_ang, is_cmd, flag, more;
  logic        go_pkt;
  logic [1:0]  nxt_m;
  logic        any_after;
  logic [7:0]  b;
  logic        take;

  assign is_ang = job.is_frame && job.kind == TYPE_ANGLE;
  assign is_cmd = job.is_frame && (job.kind == TYPE_CMD4 || job.kind == TYPE_CMD5 ||
                  job.kind == TYPE_CMD6);
  assign ang    = job.payload[mot_r*32 +: 32];

  fcmb_scale u_scale (.clk(clk), .start(sstart), .ang(ang), .res(sres));

  function automatic logic flag_of(fcmb_job_t j, logic [1:0] k);
    flag_of = j.payload[k*32 +: 8] != 8'd0;
  endfunction

  // frame that sends at least one packet
  assign go_pkt = is_ang || (is_cmd && (flag_of(job, 2'd0) || flag_of(job, 2'd1) ||
                  flag_of(job, 2'd2)));

  // is there a packet for a motor after the current one
  always_comb begin
    any_after = 1'b0;
    nxt_m = mot_r;
    for (int k = MOTOR_COUNT - 1; k >= 0; k--) begin
      if (2'(k) > mot_r && (is_ang || flag_of(job, 2'(k)))) begin
        any_after = 1'b1;
        nxt_m = 2'(k);
      end
    end
  end

  assign flag   = is_ang || flag_of(job, mot_r);
  assign more   = any_after;
  assign take   = !out_valid || !out_stall;
  assign sstart = st_r == ST_CALC;

  always_comb begin
    unique case (byt_r)
      3'd0: b = 8'(mot_r) + 8'd1;
      3'd1: b = job.kind;
      3'd2: b = word_r[7:0];
      3'd3: b = word_r[15:8];
      3'd4: b = word_r[23:16];
      default: b = word_r[31:24];
    endcase
  end

  assign job_ready = (st_r == ST_IDLE && take && !go_pkt) ||
                     (st_r == ST_SEND && take && byt_r == 3'd5 && !more);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      out_valid <= 1'b0;
      mot_r     <= 2'd0;
      byt_r     <= 3'd0;
      wait_r    <= 2'd0;
    end else begin
      if (take) out_valid <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (job_valid && take) begin
            if (!go_pkt) begin
              out_valid       <= 1'b1;
              out_tx_valid    <= 1'b0;
              out_tx_byte     <= 8'd0;
              out_tx_last     <= 1'b1;
              out_ok_led      <= job.ok_led;
              out_discard_led <= job.discard_led;
            end else begin
              mot_r  <= 2'd0;
              st_r   <= ST_CALC;
              wait_r <= 2'd0;
            end
          end
        end
        ST_CALC: begin
          if (!flag) begin
            mot_r <= nxt_m;
          end else begin
            wait_r <= wait_r + 2'd1;
            // scaled angle has reached sres once wait_r is 3
            if (wait_r == 2'd3 || !is_ang) begin
              word_r <= is_ang ? sres : 32'd0;
              byt_r  <= 3'd0;
              st_r   <= ST_SEND;
            end
          end
        end
        default: begin
          if (take) begin
            out_valid       <= 1'b1;
            out_tx_valid    <= 1'b1;
            out_tx_byte     <= b;
            out_tx_last     <= byt_r == 3'd5 && !more;
            out_ok_led      <= job.ok_led;
            out_discard_led <= job.discard_led;
            byt_r           <= byt_r + 3'd1;
            if (byt_r == 3'd5) begin
              if (more) begin
                mot_r  <= nxt_m;
                wait_r <= 2'd0;
                st_r   <= ST_CALC;
              end else begin
                st_r <= ST_IDLE;
              end
            end
          end
        end
      endcase
    end
  end

endmodule
